// File: rtl/core/diff_drive_rate_limited_ik_top_assert.svh
// assertion macros for the diff drive wheel speed block and its port checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef DIFF_DRIVE_RATE_LIMITED_IK_TOP_ASSERT_SVH
`define DIFF_DRIVE_RATE_LIMITED_IK_TOP_ASSERT_SVH

// same-cycle implication
`define DDRL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddrl assertion failed");

// next-cycle implication
`define DDRL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddrl assertion failed");

`endif

// File: rtl/core/ddrl_pkg.sv
// shared constants, register codes and helper functions of the diff drive block
// no dependencies
`default_nettype none

package ddrl_pkg;

    localparam int NUM_WHEELS = 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    // p0, p1, p2, sqrt, p3, divide, p4
    localparam int PLANE_LAT  = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    typedef enum logic [2:0] {
        CFG_LIN_STEP   = 3'd0,
        CFG_ANG_STEP   = 3'd1,
        CFG_LIN_MAX    = 3'd2,
        CFG_ANG_MAX    = 3'd3,
        CFG_HALF_TRACK = 3'd4,
        CFG_INV_RADIUS = 3'd5,
        CFG_WHEEL_MASK = 3'd6
    } cfg_index_t;

    function automatic logic signed [32:0] clamp_sym(input logic signed [32:0] v,
                                                     input logic [30:0] lim);
        logic signed [32:0] l;
        begin
            l = $signed({2'b00, lim});
            if (v > l)
                return l;
            else if (v < -l)
                return -l;
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        begin
            if (v > 66'sh0_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (v < -66'sh0_8000_0000)
                return 32'sh8000_0000;
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ddrl_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on ddrl_pkg
`default_nettype none

module ddrl_isqrt
    import ddrl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] radicand,
    output logic             out_valid,
    output logic [31:0]      root
);

    logic        vld_reg  [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic [63:0] rad_reg  [SQRT_STEPS];

    logic        vld_in   [SQRT_STEPS];
    logic [33:0] rem_in   [SQRT_STEPS];
    logic [31:0] root_in  [SQRT_STEPS];
    logic [63:0] rad_in   [SQRT_STEPS];

    logic [33:0] rem_next  [SQRT_STEPS];
    logic [31:0] root_next [SQRT_STEPS];

    always_comb
    begin
        vld_in[0]  = in_valid;
        rem_in[0]  = '0;
        root_in[0] = '0;
        rad_in[0]  = radicand;
        for (int s = 1; s < SQRT_STEPS; s++)
        begin
            vld_in[s]  = vld_reg[s-1];
            rem_in[s]  = rem_reg[s-1];
            root_in[s] = root_reg[s-1];
            rad_in[s]  = rad_reg[s-1];
        end
    end

    // stage s brings down the next two radicand bits from the top
    always_comb
    begin
        logic [35:0] sh;
        logic [35:0] trial;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            sh    = {rem_in[s], rad_in[s][2*(SQRT_STEPS-1-s) +: 2]};
            trial = {2'b00, root_in[s], 2'b01};
            if (sh >= trial)
            begin
                rem_next[s]  = 34'(sh - trial);
                root_next[s] = {root_in[s][30:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = sh[33:0];
                root_next[s] = {root_in[s][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STEPS; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < SQRT_STEPS; s++)
                vld_reg[s] <= vld_in[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            rad_reg[s]  <= rad_in[s];
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/ddrl_div.sv
// pipelined restoring divider, one quotient bit per stage
// quotient must fit 32 bits (dividend < divisor * 2^32); depends on ddrl_pkg
`default_nettype none

module ddrl_div
    import ddrl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] dividend,
    input  wire logic [33:0] divisor,
    output logic             out_valid,
    output logic [31:0]      quotient
);

    logic        vld_reg [DIV_STEPS];
    logic [33:0] rem_reg [DIV_STEPS];
    logic [31:0] low_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];
    logic [33:0] dsr_reg [DIV_STEPS];

    logic        vld_in [DIV_STEPS];
    logic [33:0] rem_in [DIV_STEPS];
    logic [31:0] low_in [DIV_STEPS];
    logic [31:0] quo_in [DIV_STEPS];
    logic [33:0] dsr_in [DIV_STEPS];

    logic [33:0] rem_next [DIV_STEPS];
    logic [31:0] quo_next [DIV_STEPS];

    always_comb
    begin
        vld_in[0] = in_valid;
        rem_in[0] = {2'b00, dividend[63:32]};
        low_in[0] = dividend[31:0];
        quo_in[0] = '0;
        dsr_in[0] = divisor;
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            vld_in[s] = vld_reg[s-1];
            rem_in[s] = rem_reg[s-1];
            low_in[s] = low_reg[s-1];
            quo_in[s] = quo_reg[s-1];
            dsr_in[s] = dsr_reg[s-1];
        end
    end

    always_comb
    begin
        logic [34:0] sh;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            sh          = {rem_in[s], low_in[s][DIV_STEPS-1-s]};
            quo_next[s] = quo_in[s];
            if (sh >= {1'b0, dsr_in[s]})
            begin
                rem_next[s]                  = 34'(sh - {1'b0, dsr_in[s]});
                quo_next[s][DIV_STEPS-1-s]   = 1'b1;
            end
            else
            begin
                rem_next[s] = sh[33:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                vld_reg[s] <= vld_in[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            low_reg[s] <= low_in[s];
            quo_reg[s] <= quo_next[s];
            dsr_reg[s] <= dsr_in[s];
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quotient  = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/ddrl_plane.sv
// planar norm limiter: scales (x, y) onto lim when its length exceeds lim
// uses ddrl_isqrt and two ddrl_div
`default_nettype none

module ddrl_plane
    import ddrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [33:0] in_x,
    input  wire logic signed [33:0] in_y,
    input  wire logic [30:0]        lim,
    output logic                    out_valid,
    output logic signed [33:0]      out_x,
    output logic signed [33:0]      out_y
);

    typedef struct packed {
        logic [1:0]  k;
        logic [32:0] ma;
        logic [32:0] mb;
        logic        sx;
        logic        sy;
    } mag_side_t;

    typedef struct packed {
        logic        over;
        logic [32:0] ma;
        logic [32:0] mb;
        logic        sx;
        logic        sy;
    } div_side_t;

    // p0: magnitudes and common pre-shift
    logic [33:0] ax, bx;
    logic [32:0] mor;
    logic [1:0]  k0;
    logic        p0_vld_reg;
    mag_side_t   p0_side_reg;
    logic [30:0] p0_a_reg, p0_b_reg;

    assign ax  = in_x[33] ? 34'(-in_x) : 34'(in_x);
    assign bx  = in_y[33] ? 34'(-in_y) : 34'(in_y);
    assign mor = ax[32:0] | bx[32:0];
    assign k0  = mor[32] ? 2'd2 : (mor[31] ? 2'd1 : 2'd0);

    // p1: squares, p2: sum
    logic        p1_vld_reg, p2_vld_reg;
    mag_side_t   p1_side_reg, p2_side_reg;
    logic [61:0] p1_sqa_reg, p1_sqb_reg;
    logic [62:0] p2_sum_reg;

    // sqrt and side data alongside it
    logic        sq_vld;
    logic [31:0] sq_root;
    mag_side_t   sa_reg [SQRT_STEPS];

    // p3: length, limit test, products
    logic        p3_vld_reg;
    div_side_t   p3_side_reg;
    logic [33:0] p3_n_reg;
    logic [63:0] p3_px_reg, p3_py_reg;
    logic [33:0] n3;
    mag_side_t   sq_side;

    assign sq_side = sa_reg[SQRT_STEPS-1];
    assign n3      = {2'b00, sq_root} << sq_side.k;

    // divide
    logic        dx_vld, dy_vld;
    logic [31:0] qx, qy;
    div_side_t   sb_reg [DIV_STEPS];
    div_side_t   dv_side;

    assign dv_side = sb_reg[DIV_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            p0_vld_reg <= in_valid;
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= sq_vld;
            out_valid  <= dx_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_side_reg.k  <= k0;
        p0_side_reg.ma <= ax[32:0];
        p0_side_reg.mb <= bx[32:0];
        p0_side_reg.sx <= in_x[33];
        p0_side_reg.sy <= in_y[33];
        p0_a_reg       <= 31'(ax[32:0] >> k0);
        p0_b_reg       <= 31'(bx[32:0] >> k0);

        p1_side_reg <= p0_side_reg;
        p1_sqa_reg  <= p0_a_reg * p0_a_reg;
        p1_sqb_reg  <= p0_b_reg * p0_b_reg;

        p2_side_reg <= p1_side_reg;
        p2_sum_reg  <= {1'b0, p1_sqa_reg} + {1'b0, p1_sqb_reg};

        sa_reg[0] <= p2_side_reg;
        for (int i = 1; i < SQRT_STEPS; i++)
            sa_reg[i] <= sa_reg[i-1];

        p3_side_reg.over <= n3 > {3'b000, lim};
        p3_side_reg.ma   <= sq_side.ma;
        p3_side_reg.mb   <= sq_side.mb;
        p3_side_reg.sx   <= sq_side.sx;
        p3_side_reg.sy   <= sq_side.sy;
        p3_n_reg         <= n3;
        p3_px_reg        <= sq_side.ma * lim;
        p3_py_reg        <= sq_side.mb * lim;

        sb_reg[0] <= p3_side_reg;
        for (int i = 1; i < DIV_STEPS; i++)
            sb_reg[i] <= sb_reg[i-1];

        // untouched components come back from sign and magnitude
        if (dv_side.over)
        begin
            out_x <= dv_side.sx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
            out_y <= dv_side.sy ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
        end
        else
        begin
            out_x <= dv_side.sx ? -$signed({1'b0, dv_side.ma}) : $signed({1'b0, dv_side.ma});
            out_y <= dv_side.sy ? -$signed({1'b0, dv_side.mb}) : $signed({1'b0, dv_side.mb});
        end
    end

    ddrl_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_vld_reg),
        .radicand  ({1'b0, p2_sum_reg}),
        .out_valid (sq_vld),
        .root      (sq_root)
    );

    ddrl_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_vld_reg),
        .dividend  (p3_px_reg),
        .divisor   (p3_n_reg),
        .out_valid (dx_vld),
        .quotient  (qx)
    );

    ddrl_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_vld_reg),
        .dividend  (p3_py_reg),
        .divisor   (p3_n_reg),
        .out_valid (dy_vld),
        .quotient  (qy)
    );

    // both dividers run in lockstep, dy_vld only mirrors dx_vld
    logic unused_dy;
    assign unused_dy = dy_vld;

endmodule

`default_nettype wire

// File: rtl/core/diff_drive_rate_limited_ik_top.sv
// top level of the rate limited differential drive wheel speed block
// uses ddrl_pkg and two ddrl_plane limiters
//
//  channel   | signals                                   | transaction
//  ----------+-------------------------------------------+----------------------------
//  command   | start, busy, target_*, present_*          | edge with start & !busy
//  result    | result_strobe, wheel_index/speed, last    | every edge with strobe high
//  config    | cfg_we, cfg_index, cfg_data               | every edge with cfg_we high
//
// after each taken command busy holds off the next one, so that the result bursts of
// two commands never overlap; the result port sends one wheel per cycle.
// the path runs through two norm limiters in series, each a 32 stage sqrt
// followed by two 32 stage dividers working side by side.
// reset clears valid bits and sets config to defaults; results cannot be held off.
`default_nettype none

module diff_drive_rate_limited_ik_top
    import ddrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] target_vx,
    input  wire logic signed [31:0] target_vy,
    input  wire logic signed [31:0] target_wz,
    input  wire logic signed [31:0] present_vx,
    input  wire logic signed [31:0] present_vy,
    input  wire logic signed [31:0] present_wz,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    output logic                    result_strobe,
    output logic [2:0]              wheel_index,
    output logic signed [31:0]      wheel_speed,
    output logic                    last_wheel
);

    typedef struct packed {
        logic signed [32:0] dwc;
        logic signed [31:0] pvx;
        logic signed [31:0] pvy;
        logic signed [31:0] pwz;
    } step_side_t;

    // configuration
    logic [30:0] lin_step_reg, ang_step_reg, lin_max_reg, ang_max_reg;
    logic [30:0] half_track_reg, inv_radius_reg;
    logic [7:0]  mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_step_reg   <= '0;
            ang_step_reg   <= '0;
            lin_max_reg    <= '0;
            ang_max_reg    <= '0;
            half_track_reg <= 31'd32768;
            inv_radius_reg <= 31'd65536;
            mask_reg       <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LIN_STEP:   lin_step_reg   <= cfg_data;
                CFG_ANG_STEP:   ang_step_reg   <= cfg_data;
                CFG_LIN_MAX:    lin_max_reg    <= cfg_data;
                CFG_ANG_MAX:    ang_max_reg    <= cfg_data;
                CFG_HALF_TRACK: half_track_reg <= cfg_data;
                CFG_INV_RADIUS: inv_radius_reg <= cfg_data;
                CFG_WHEEL_MASK: mask_reg       <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // command spacing
    logic       accept;
    logic [2:0] busy_cnt_reg;

    assign accept = start && !busy;
    assign busy   = busy_cnt_reg != 3'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_cnt_reg <= '0;
        else if (accept)
            busy_cnt_reg <= 3'(NUM_WHEELS - 1);
        else if (busy)
            busy_cnt_reg <= busy_cnt_reg - 3'd1;
    end

    // s0 capture, s1 velocity step
    logic               s0_vld_reg, s1_vld_reg;
    logic signed [31:0] s0_tvx_reg, s0_tvy_reg, s0_twz_reg;
    logic signed [31:0] s0_pvx_reg, s0_pvy_reg, s0_pwz_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg, s1_dw_reg;
    logic signed [31:0] s1_pvx_reg, s1_pvy_reg, s1_pwz_reg;

    // step limiter and side data
    logic               l1_vld;
    logic signed [33:0] l1_x, l1_y;
    step_side_t         st_side_reg [PLANE_LAT];
    step_side_t         st_side_in;
    step_side_t         st_out;

    assign st_side_in.dwc = clamp_sym(s1_dw_reg, ang_step_reg);
    assign st_side_in.pvx = s1_pvx_reg;
    assign st_side_in.pvy = s1_pvy_reg;
    assign st_side_in.pwz = s1_pwz_reg;
    assign st_out         = st_side_reg[PLANE_LAT-1];

    // s3 new velocity
    logic               s3_vld_reg;
    logic signed [33:0] s3_vx_reg, s3_vy_reg;
    logic signed [32:0] s3_wz_reg;

    // speed limiter
    logic               l2_vld;
    logic signed [33:0] l2_x, l2_y;
    logic signed [32:0] wz_side_reg [PLANE_LAT];

    // wheel math
    logic               m0_vld_reg, m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    logic signed [64:0] m0_t_reg;
    logic signed [33:0] m0_vx_reg;
    logic signed [49:0] m1_sr_reg, m1_sl_reg;
    logic [54:0]        m2_lor_reg, m2_lol_reg, m3_lor_reg, m3_lol_reg;
    logic signed [25:0] m2_hir_reg, m2_hil_reg;
    logic signed [57:0] m3_hpr_reg, m3_hpl_reg;
    logic signed [31:0] m4_right_reg, m4_left_reg;

    logic signed [48:0] t1;
    logic signed [81:0] full_r, full_l;

    assign t1     = m0_t_reg[64:16];
    assign full_r = $signed({m3_hpr_reg, 24'b0}) + $signed({27'b0, m3_lor_reg});
    assign full_l = $signed({m3_hpl_reg, 24'b0}) + $signed({27'b0, m3_lol_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            m0_vld_reg <= 1'b0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= accept;
            s1_vld_reg <= s0_vld_reg;
            s3_vld_reg <= l1_vld;
            m0_vld_reg <= l2_vld;
            m1_vld_reg <= m0_vld_reg;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_tvx_reg <= target_vx;
            s0_tvy_reg <= target_vy;
            s0_twz_reg <= target_wz;
            s0_pvx_reg <= present_vx;
            s0_pvy_reg <= present_vy;
            s0_pwz_reg <= present_wz;
        end

        s1_dx_reg  <= $signed({s0_tvx_reg[31], s0_tvx_reg}) - $signed({s0_pvx_reg[31], s0_pvx_reg});
        s1_dy_reg  <= $signed({s0_tvy_reg[31], s0_tvy_reg}) - $signed({s0_pvy_reg[31], s0_pvy_reg});
        s1_dw_reg  <= $signed({s0_twz_reg[31], s0_twz_reg}) - $signed({s0_pwz_reg[31], s0_pwz_reg});
        s1_pvx_reg <= s0_pvx_reg;
        s1_pvy_reg <= s0_pvy_reg;
        s1_pwz_reg <= s0_pwz_reg;

        st_side_reg[0] <= st_side_in;
        for (int i = 1; i < PLANE_LAT; i++)
            st_side_reg[i] <= st_side_reg[i-1];

        s3_vx_reg <= $signed({{2{st_out.pvx[31]}}, st_out.pvx}) + l1_x;
        s3_vy_reg <= $signed({{2{st_out.pvy[31]}}, st_out.pvy}) + l1_y;
        s3_wz_reg <= $signed({st_out.pwz[31], st_out.pwz}) + st_out.dwc;

        wz_side_reg[0] <= clamp_sym(s3_wz_reg, ang_max_reg);
        for (int i = 1; i < PLANE_LAT; i++)
            wz_side_reg[i] <= wz_side_reg[i-1];

        // half track times yaw rate
        m0_t_reg  <= wz_side_reg[PLANE_LAT-1] * $signed({1'b0, half_track_reg});
        m0_vx_reg <= l2_x;

        m1_sr_reg <= $signed({{16{m0_vx_reg[33]}}, m0_vx_reg}) + $signed({t1[48], t1});
        m1_sl_reg <= $signed({{16{m0_vx_reg[33]}}, m0_vx_reg}) - $signed({t1[48], t1});

        // times inverse radius, split in a low and a high partial product
        m2_lor_reg <= m1_sr_reg[23:0] * inv_radius_reg;
        m2_lol_reg <= m1_sl_reg[23:0] * inv_radius_reg;
        m2_hir_reg <= m1_sr_reg[49:24];
        m2_hil_reg <= m1_sl_reg[49:24];

        m3_hpr_reg <= m2_hir_reg * $signed({1'b0, inv_radius_reg});
        m3_hpl_reg <= m2_hil_reg * $signed({1'b0, inv_radius_reg});
        m3_lor_reg <= m2_lor_reg;
        m3_lol_reg <= m2_lol_reg;

        m4_right_reg <= sat32(full_r[81:16]);
        m4_left_reg  <= sat32(full_l[81:16]);
    end

    ddrl_plane u_step_lim (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .in_x      ($signed({s1_dx_reg[32], s1_dx_reg})),
        .in_y      ($signed({s1_dy_reg[32], s1_dy_reg})),
        .lim       (lin_step_reg),
        .out_valid (l1_vld),
        .out_x     (l1_x),
        .out_y     (l1_y)
    );

    ddrl_plane u_speed_lim (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .in_x      (s3_vx_reg),
        .in_y      (s3_vy_reg),
        .lim       (lin_max_reg),
        .out_valid (l2_vld),
        .out_x     (l2_x),
        .out_y     (l2_y)
    );

    // lateral speed only feeds the norms
    logic signed [33:0] unused_vy;
    assign unused_vy = l2_y;

    // result serializer, one wheel per cycle
    logic               ser_active_reg;
    logic [2:0]         ser_cnt_reg;
    logic signed [31:0] hold_right_reg, hold_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_active_reg  <= 1'b0;
            ser_cnt_reg     <= '0;
            result_strobe   <= 1'b0;
            wheel_index     <= '0;
            last_wheel      <= 1'b0;
        end
        else if (m4_vld_reg)
        begin
            result_strobe  <= 1'b1;
            wheel_index    <= 3'd0;
            last_wheel     <= NUM_WHEELS == 1;
            ser_active_reg <= NUM_WHEELS > 1;
            ser_cnt_reg    <= 3'd1;
        end
        else if (ser_active_reg)
        begin
            result_strobe <= 1'b1;
            wheel_index   <= ser_cnt_reg;
            last_wheel    <= ser_cnt_reg == 3'(NUM_WHEELS - 1);
            if (ser_cnt_reg == 3'(NUM_WHEELS - 1))
                ser_active_reg <= 1'b0;
            else
                ser_cnt_reg <= ser_cnt_reg + 3'd1;
        end
        else
        begin
            result_strobe <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m4_vld_reg)
        begin
            hold_right_reg <= m4_right_reg;
            hold_left_reg  <= m4_left_reg;
            wheel_speed    <= mask_reg[0] ? m4_right_reg : m4_left_reg;
        end
        else if (ser_active_reg)
        begin
            wheel_speed <= mask_reg[ser_cnt_reg] ? hold_right_reg : hold_left_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ddrl_checker.sv
// port level checker for the diff drive wheel speed block, bound to the top level
// uses ddrl_pkg and diff_drive_rate_limited_ik_top_assert.svh
`default_nettype none

`include "diff_drive_rate_limited_ik_top_assert.svh"

module ddrl_checker
    import ddrl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_strobe,
    input wire logic [2:0]  wheel_index,
    input wire logic        last_wheel
);

    // a taken command blocks the next one
    `DDRL_ASSERT_NXT(a_busy_after_start, start && !busy, busy)

    // wheels of one transaction come out back to back in order
    `DDRL_ASSERT_NXT(a_wheels_in_order, result_strobe && !last_wheel, result_strobe && (wheel_index == $past(wheel_index) + 3'd1))

    `DDRL_ASSERT_IMP(a_last_is_top_wheel, result_strobe && last_wheel, wheel_index == 3'(NUM_WHEELS - 1))

    `DDRL_ASSERT_IMP(a_later_wheel_follows, result_strobe && (wheel_index != 3'd0), $past(result_strobe))

endmodule

bind diff_drive_rate_limited_ik_top ddrl_checker u_ddrl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .wheel_index   (wheel_index),
    .last_wheel    (last_wheel)
);

`default_nettype wire
